/* src/framed_text_receiver_xor_check_top_assert.svh */
// Assertion macros for the framed text receiver.
`ifndef FRAMED_TEXT_RECEIVER_XOR_CHECK_TOP_ASSERT_SVH
`define FRAMED_TEXT_RECEIVER_XOR_CHECK_TOP_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define FTRX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define FTRX_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/ftrx_pkg.sv */
package ftrx_pkg;

    // Depth of the message store and derived widths.
    localparam int MSG_DEPTH = 32;
    localparam int ADDR_W    = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int CNT_W     = $clog2(MSG_DEPTH + 1);
    localparam int MAXLEN_W  = 6;
    localparam int LIM_W     = (CNT_W > MAXLEN_W) ? CNT_W : MAXLEN_W;

    // Configuration register indexes.
    localparam logic [1:0] REG_START_MARKER  = 2'd0;
    localparam logic [1:0] REG_END_MARKER    = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH    = 2'd2;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0]  START_MARKER_RST  = 8'd35;
    localparam logic [7:0]  END_MARKER_RST    = 8'd36;
    localparam logic [5:0]  MAX_LENGTH_RST    = 6'd25;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd500;

    // Input kinds and result verdicts.
    localparam logic       KIND_BYTE = 1'b0;
    localparam logic       KIND_TICK = 1'b1;
    localparam logic [1:0] VERDICT_NACK = 2'd0;
    localparam logic [1:0] VERDICT_ACK  = 2'd1;
    localparam logic [1:0] VERDICT_CHAR = 2'd2;

    // Letters, digits, space and the punctuation ! . + - , are allowed.
    function automatic logic allowed_char(input logic [7:0] b);
        logic ok;
        ok = ((b >= 8'h41) && (b <= 8'h5A)) ||
             ((b >= 8'h61) && (b <= 8'h7A)) ||
             ((b >= 8'h30) && (b <= 8'h39)) ||
             (b == 8'h20) || (b == 8'h21) || (b == 8'h2E) ||
             (b == 8'h2B) || (b == 8'h2D) || (b == 8'h2C);
        return ok;
    endfunction

endpackage

/* src/ftrx_msg_ram.sv */
module ftrx_msg_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/framed_text_receiver_xor_check_top.sv */
// Channel   Direction  Handshake            Payload
// s_        input      s_valid / s_ready    s_kind, s_data_byte
// m_        output     m_valid / m_ready    m_verdict, m_char_out, m_last
// cfg_      input      cfg_we (no wait)     cfg_index, cfg_wdata
//
// A received byte or tick is processed in the cycle it is transferred; a NACK or ACK
// is loaded into the output register in that same cycle.
// After an ACK, each stored character passes through two steps: a message store read in
// ST_FETCH, which waits while a result is stalled, and a load of the output register in ST_LOAD.
// The input is not ready while the character burst runs or while a result is stalled.
// Reset is synchronous and active low; the message store itself is not cleared.
module framed_text_receiver_xor_check_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_verdict,
    output logic [7:0]  m_char_out,
    output logic        m_last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int CNT_W  = ftrx_pkg::CNT_W;
    localparam int ADDR_W = ftrx_pkg::ADDR_W;
    localparam int LIM_W  = ftrx_pkg::LIM_W;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FETCH,
        ST_LOAD
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TEXT,
        PH_SUM
    } phase_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [7:0]         xor_reg, xor_next;
    logic               good_reg, good_next;
    logic [15:0]        quiet_reg, quiet_next;

    logic [7:0]         start_marker_reg;
    logic [7:0]         end_marker_reg;
    logic [5:0]         max_length_reg;
    logic [15:0]        timeout_reg;

    logic               m_valid_reg, m_valid_next;
    logic [1:0]         verdict_reg, verdict_next;
    logic [7:0]         char_reg, char_next;
    logic               last_reg, last_next;

    logic               out_free;
    logic               out_load;
    logic               in_fire;
    logic [15:0]        quiet_inc;
    logic [LIM_W-1:0]   limit;
    logic               full;
    logic [CNT_W-1:0]   rd_idx_inc;
    logic               ram_we;
    logic [7:0]         ram_rdata;

    ftrx_msg_ram #(
        .DEPTH (ftrx_pkg::MSG_DEPTH),
        .WIDTH (8),
        .ADDR_W(ADDR_W)
    ) u_msg_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(s_data_byte),
        .raddr(rd_idx_reg[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_RUN) && out_free;
    assign in_fire  = s_valid && s_ready;

    // Saturating quiet tick count and the clamped length limit.
    assign quiet_inc  = (quiet_reg != 16'hFFFF) ? quiet_reg + 16'd1 : quiet_reg;
    assign limit      = (LIM_W'(max_length_reg) > LIM_W'(ftrx_pkg::MSG_DEPTH)) ?
                        LIM_W'(ftrx_pkg::MSG_DEPTH) : LIM_W'(max_length_reg);
    assign full       = LIM_W'(count_reg) >= limit;
    assign rd_idx_inc = rd_idx_reg + CNT_W'(1);

    // Frame tracking and result selection.
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        xor_next     = xor_reg;
        good_next    = good_reg;
        quiet_next   = quiet_reg;
        out_load     = 1'b0;
        verdict_next = verdict_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        ram_we       = 1'b0;

        unique case (state_reg)
            ST_RUN: begin
                if (in_fire) begin
                    unique case (phase_reg) inside
                        PH_TEXT, PH_SUM: begin
                            if (s_kind == ftrx_pkg::KIND_TICK) begin
                                quiet_next = quiet_inc;
                                if (quiet_inc >= timeout_reg) begin
                                    out_load     = 1'b1;
                                    verdict_next = ftrx_pkg::VERDICT_NACK;
                                    char_next    = 8'd0;
                                    last_next    = 1'b1;
                                    phase_next   = PH_IDLE;
                                end
                            end else if (phase_reg == PH_TEXT) begin
                                quiet_next = 16'd0;
                                if (s_data_byte == end_marker_reg) begin
                                    phase_next = PH_SUM;
                                end else if (!ftrx_pkg::allowed_char(s_data_byte) || full) begin
                                    good_next = 1'b0;
                                end else if (good_reg) begin
                                    ram_we     = 1'b1;
                                    xor_next   = xor_reg ^ s_data_byte;
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end else begin
                                // Checksum byte closes the frame.
                                out_load   = 1'b1;
                                char_next  = 8'd0;
                                phase_next = PH_IDLE;
                                if (!good_reg || (xor_reg != s_data_byte)) begin
                                    verdict_next = ftrx_pkg::VERDICT_NACK;
                                    last_next    = 1'b1;
                                end else begin
                                    verdict_next = ftrx_pkg::VERDICT_ACK;
                                    last_next    = (count_reg == '0);
                                    rd_idx_next  = '0;
                                    if (count_reg != '0) begin
                                        state_next = ST_FETCH;
                                    end
                                end
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                            if (s_kind == ftrx_pkg::KIND_BYTE) begin
                                if (s_data_byte == start_marker_reg) begin
                                    phase_next = PH_TEXT;
                                    count_next = '0;
                                    xor_next   = 8'd0;
                                    good_next  = 1'b1;
                                    quiet_next = 16'd0;
                                end else begin
                                    out_load     = 1'b1;
                                    verdict_next = ftrx_pkg::VERDICT_NACK;
                                    char_next    = 8'd0;
                                    last_next    = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                // The read is issued only once the output register will be empty.
                if (out_free) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                out_load     = 1'b1;
                verdict_next = ftrx_pkg::VERDICT_CHAR;
                char_next    = ram_rdata;
                last_next    = (rd_idx_inc == count_reg);
                rd_idx_next  = rd_idx_inc;
                state_next   = (rd_idx_inc == count_reg) ? ST_RUN : ST_FETCH;
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // State, configuration and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_RUN;
            phase_reg        <= PH_IDLE;
            count_reg        <= '0;
            rd_idx_reg       <= '0;
            xor_reg          <= 8'd0;
            good_reg         <= 1'b0;
            quiet_reg        <= 16'd0;
            start_marker_reg <= ftrx_pkg::START_MARKER_RST;
            end_marker_reg   <= ftrx_pkg::END_MARKER_RST;
            max_length_reg   <= ftrx_pkg::MAX_LENGTH_RST;
            timeout_reg      <= ftrx_pkg::TIMEOUT_TICKS_RST;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            xor_reg     <= xor_next;
            good_reg    <= good_next;
            quiet_reg   <= quiet_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    ftrx_pkg::REG_START_MARKER:  start_marker_reg <= cfg_wdata[7:0];
                    ftrx_pkg::REG_END_MARKER:    end_marker_reg   <= cfg_wdata[7:0];
                    ftrx_pkg::REG_MAX_LENGTH:    max_length_reg   <= cfg_wdata[5:0];
                    ftrx_pkg::REG_TIMEOUT_TICKS: timeout_reg      <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        verdict_reg <= verdict_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_verdict  = verdict_reg;
    assign m_char_out = char_reg;
    assign m_last     = last_reg;

    `include "framed_text_receiver_xor_check_top_assert.svh"

    // The burst never reads beyond the stored characters.
    `FTRX_ASSERT_IMPL(a_burst_idx, state_reg != ST_RUN, rd_idx_reg < count_reg,
        "burst read index past stored count")
    // The stored count never exceeds the store depth.
    `FTRX_ASSERT(a_count_bound, count_reg <= CNT_W'(ftrx_pkg::MSG_DEPTH),
        "stored count exceeds message store depth")
    // A result is never loaded over one that is still stalled.
    `FTRX_ASSERT_IMPL(a_no_overwrite, out_load, out_free,
        "output register overwritten while stalled")
    // Read data is used only in the cycle after its read was issued.
    `FTRX_ASSERT_IMPL(a_load_after_fetch, state_reg == ST_LOAD, $past(state_reg) == ST_FETCH,
        "character load without a preceding read")

endmodule

/* tb/testbench.sv */
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // One result transfer as seen on the m_ side.
    typedef struct packed {
        logic [1:0] verdict;
        logic [7:0] ch;
        logic       last;
    } reply_t;

    // Side information that travels with each offered input item.
    typedef struct packed {
        logic   typed;
        reply_t reply;
    } hint_t;

    // One row of the directed stimulus.
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       use_sum;
        logic       typed;
        reply_t     reply;
    } step_vec_t;

    typedef enum logic [1:0] {RX_IDLE, RX_TEXT, RX_SUM} rx_phase_t;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 250;
    localparam int PHASE_ITEMS = 65;
    localparam int N_SETTINGS  = 6;

    localparam reply_t NACK_ITEM      = '{ftrx_pkg::VERDICT_NACK, 8'h00, 1'b1};
    localparam reply_t EMPTY_ACK_ITEM = '{ftrx_pkg::VERDICT_ACK, 8'h00, 1'b1};

    localparam logic [7:0] PUNCT [6] = '{8'h20, 8'h21, 8'h2E, 8'h2B, 8'h2D, 8'h2C};

    // Register settings walked by the random part; extremes included.
    localparam logic [7:0]  SET_START   [N_SETTINGS] =
        '{8'h00, 8'h23, 8'h41, 8'hFF, 8'h7E, 8'h23};
    localparam logic [7:0]  SET_END     [N_SETTINGS] =
        '{8'hFF, 8'h24, 8'h2E, 8'h00, 8'h21, 8'h24};
    localparam logic [5:0]  SET_MAXLEN  [N_SETTINGS] =
        '{6'd1, 6'd32, 6'd8, 6'd63, 6'd0, 6'd25};
    localparam logic [15:0] SET_TIMEOUT [N_SETTINGS] =
        '{16'd1, 16'd65535, 16'd3, 16'd5, 16'd0, 16'd12};

    // Directed rows, run with the registers at their reset values.
    localparam step_vec_t DIRECTED [23] = '{
        '{ftrx_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h00, 1'b0, 1'b1, NACK_ITEM},
        '{ftrx_pkg::KIND_BYTE, 8'hFF, 1'b0, 1'b1, NACK_ITEM},
        '{ftrx_pkg::KIND_BYTE, 8'h23, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h24, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h00, 1'b0, 1'b1, EMPTY_ACK_ITEM},
        '{ftrx_pkg::KIND_BYTE, 8'h23, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h48, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h69, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h21, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h24, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h00, 1'b1, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h23, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h61, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h23, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h24, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h00, 1'b1, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h23, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_TICK, 8'hA5, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h5A, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_TICK, 8'h5A, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h24, 1'b0, 1'b0, '0},
        '{ftrx_pkg::KIND_BYTE, 8'h00, 1'b0, 1'b1, NACK_ITEM}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_verdict;
    logic [7:0]  m_char_out;
    logic        m_last;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    // Predicted receiver state and register copies.
    rx_phase_t   p_phase;
    logic [7:0]  p_store [32];
    int          p_cnt;
    logic [7:0]  p_xor;
    logic        p_good;
    logic [15:0] p_quiet;
    logic [7:0]  p_start;
    logic [7:0]  p_end;
    logic [5:0]  p_maxlen;
    logic [15:0] p_timeout;

    reply_t step_out [$];
    reply_t replies_due [$];
    hint_t  hints [$];

    int mismatches   = 0;
    int sent         = 0;
    int burst_left   = 0;
    int stall_cycles = 0;
    int hold_asks    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int win_left     = 0;
    int win_mode     = 0;

    framed_text_receiver_xor_check_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_verdict   (m_verdict),
        .m_char_out  (m_char_out),
        .m_last      (m_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Characters that a good frame may carry.
    function automatic bit in_text_set(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                         8'h20, 8'h21, 8'h2B, 8'h2C, 8'h2D, 8'h2E};
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        int k;
        do begin
            k = $urandom_range(0, 67);
            if (k < 26) begin
                c = 8'(8'h41 + k);
            end else if (k < 52) begin
                c = 8'(8'h61 + k - 26);
            end else if (k < 62) begin
                c = 8'(8'h30 + k - 52);
            end else begin
                c = PUNCT[k - 62];
            end
        end while (c == p_end);
        return c;
    endfunction

    function automatic logic [7:0] odd_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (in_text_set(c) || c == p_end);
        return c;
    endfunction

    function automatic void emit_nack();
        step_out.push_back(NACK_ITEM);
        p_phase = RX_IDLE;
    endfunction

    function automatic void frame_tick();
        if (p_quiet != 16'hFFFF) p_quiet++;
        if (p_quiet >= p_timeout) emit_nack();
    endfunction

    // Advance the predicted receiver by one input transfer.
    function automatic void rx_step(input logic kind, input logic [7:0] b);
        int lim;
        lim = (p_maxlen > 6'd32) ? 32 : int'(p_maxlen);
        step_out.delete();
        case (p_phase)
            RX_TEXT: begin
                if (kind == ftrx_pkg::KIND_TICK) begin
                    frame_tick();
                end else begin
                    p_quiet = 16'h0000;
                    if (b == p_end) begin
                        p_phase = RX_SUM;
                    end else if (!in_text_set(b) || p_cnt >= lim) begin
                        p_good = 1'b0;
                    end else if (p_good && p_cnt < 32) begin
                        p_store[p_cnt] = b;
                        p_xor ^= b;
                        p_cnt++;
                    end
                end
            end
            RX_SUM: begin
                if (kind == ftrx_pkg::KIND_TICK) begin
                    frame_tick();
                end else if (!p_good || p_xor != b) begin
                    emit_nack();
                end else begin
                    p_phase = RX_IDLE;
                    step_out.push_back('{ftrx_pkg::VERDICT_ACK, 8'h00, p_cnt == 0});
                    for (int i = 0; i < p_cnt; i++) begin
                        step_out.push_back('{ftrx_pkg::VERDICT_CHAR, p_store[i],
                                             i + 1 == p_cnt});
                    end
                end
            end
            default: begin
                p_phase = RX_IDLE;
                if (kind == ftrx_pkg::KIND_BYTE) begin
                    if (b == p_start) begin
                        p_phase = RX_TEXT;
                        p_cnt = 0;
                        p_xor = 8'h00;
                        p_good = 1'b1;
                        p_quiet = 16'h0000;
                    end else begin
                        emit_nack();
                    end
                end
            end
        endcase
    endfunction

    // Offer one item in bursts with random gaps; returns at its transfer.
    task automatic offer(input logic kind, input logic [7:0] b,
                         input logic typed = 1'b0, input reply_t reply = '0);
        hint_t h;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        h.typed = typed;
        h.reply = reply;
        hints.push_back(h);
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    // Stop offering and wait until every predicted result has arrived.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input int s);
        write_reg(ftrx_pkg::REG_START_MARKER, {8'h00, SET_START[s]});
        write_reg(ftrx_pkg::REG_END_MARKER, {8'h00, SET_END[s]});
        write_reg(ftrx_pkg::REG_MAX_LENGTH, {10'h000, SET_MAXLEN[s]});
        write_reg(ftrx_pkg::REG_TIMEOUT_TICKS, SET_TIMEOUT[s]);
        cfg_we <= 1'b0;
        p_start   = SET_START[s];
        p_end     = SET_END[s];
        p_maxlen  = SET_MAXLEN[s];
        p_timeout = SET_TIMEOUT[s];
    endtask

    // A frame of len characters; bad_at places one illegal byte, close adds end and checksum.
    task automatic send_frame(input int len, input int bad_at, input bit wrong_sum,
                              input bit ticks_ok, input bit close);
        logic [7:0] c;
        logic [7:0] acc;
        acc = 8'h00;
        offer(ftrx_pkg::KIND_BYTE, p_start);
        for (int i = 0; i < len; i++) begin
            if (ticks_ok && $urandom_range(0, 7) == 0) offer(ftrx_pkg::KIND_TICK, 8'($urandom));
            c = (i == bad_at) ? odd_byte() : text_char();
            acc ^= c;
            offer(ftrx_pkg::KIND_BYTE, c);
        end
        if (close) begin
            offer(ftrx_pkg::KIND_BYTE, p_end);
            offer(ftrx_pkg::KIND_BYTE, wrong_sum ? acc ^ 8'($urandom_range(1, 255)) : acc);
        end
    endtask

    // Receiver: a long hold-off on request, otherwise windows of differing stall rates.
    always @(posedge aclk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (win_left == 0) begin
                win_mode = $urandom_range(0, 2);
                win_left = $urandom_range(10, 80);
            end
            win_left--;
            case (win_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // Compare each result transfer with the oldest prediction, then predict new input.
    always @(posedge aclk) begin : scoreboard
        reply_t want;
        hint_t h;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected: verdict %0d char %h last %b",
                             $time, m_verdict, m_char_out, m_last);
                end else begin
                    want = replies_due.pop_front();
                    if (m_verdict !== want.verdict) begin
                        mismatches++;
                        $display("%0t: verdict expected %0d actual %0d",
                                 $time, want.verdict, m_verdict);
                    end
                    if (m_char_out !== want.ch) begin
                        mismatches++;
                        $display("%0t: char_out expected %h actual %h",
                                 $time, want.ch, m_char_out);
                    end
                    if (m_last !== want.last) begin
                        mismatches++;
                        $display("%0t: last expected %b actual %b", $time, want.last, m_last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                h = hints.pop_front();
                rx_step(s_kind, s_data_byte);
                if (h.typed) begin
                    replies_due.push_back(h.reply);
                end else begin
                    foreach (step_out[i]) replies_due.push_back(step_out[i]);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        step_vec_t row;
        logic [7:0] acc;
        logic [7:0] b;
        logic k;
        int lim;
        int base;
        int pick;
        int sel;
        int len;

        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_kind      <= ftrx_pkg::KIND_BYTE;
        s_data_byte <= 8'h00;
        m_ready     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= ftrx_pkg::REG_START_MARKER;
        cfg_wdata   <= 16'h0000;

        p_phase   = RX_IDLE;
        p_cnt     = 0;
        p_xor     = 8'h00;
        p_good    = 1'b0;
        p_quiet   = 16'h0000;
        p_start   = ftrx_pkg::START_MARKER_RST;
        p_end     = ftrx_pkg::END_MARKER_RST;
        p_maxlen  = ftrx_pkg::MAX_LENGTH_RST;
        p_timeout = ftrx_pkg::TIMEOUT_TICKS_RST;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows; the checksum of a good frame is accumulated on the way.
        acc = 8'h00;
        foreach (DIRECTED[i]) begin
            row = DIRECTED[i];
            b = row.use_sum ? acc : row.data;
            if (row.use_sum) begin
                acc = 8'h00;
            end else if (row.kind == ftrx_pkg::KIND_BYTE && in_text_set(row.data)) begin
                acc ^= row.data;
            end
            offer(row.kind, b, row.typed, row.reply);
        end
        drain();

        // Random frames under each register setting.
        for (int s = 0; s < N_SETTINGS; s++) begin
            apply_settings(s);
            lim = (p_maxlen > 6'd32) ? 32 : int'(p_maxlen);
            base = sent;

            // Hold the result side off while bytes keep coming, so the input stalls.
            if (s == 1) begin
                // An end marker and one more byte bring the receiver back to idle from any phase.
                offer(ftrx_pkg::KIND_BYTE, p_end);
                offer(ftrx_pkg::KIND_BYTE, 8'h00);
                hold_asks++;
                repeat (12) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == p_start) b = ~b;
                    offer(ftrx_pkg::KIND_BYTE, b);
                end
                drain();
            end

            while (sent - base < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 7) begin
                        len = $urandom_range(0, (lim < 6) ? lim : 6);
                    end else if (sel < 9) begin
                        len = lim;
                    end else begin
                        len = lim + 1;
                    end
                    send_frame(len, -1, $urandom_range(0, 9) == 0, p_timeout >= 16'd2, 1'b1);
                end else if (pick < 72) begin
                    len = $urandom_range(1, 6);
                    send_frame(len, $urandom_range(0, len - 1), 1'b0,
                               p_timeout >= 16'd2, 1'b1);
                end else if (pick < 82 && p_timeout <= 16'd40) begin
                    // Let the frame run out of ticks, in the text or before the checksum.
                    send_frame($urandom_range(0, 3), -1, 1'b0, 1'b0, 1'b0);
                    if ($urandom_range(0, 1) == 1) offer(ftrx_pkg::KIND_BYTE, p_end);
                    repeat ((p_timeout == 16'd0) ? 1 : int'(p_timeout)) begin
                        offer(ftrx_pkg::KIND_TICK, 8'($urandom));
                    end
                end else if (pick < 90) begin
                    send_frame($urandom_range(0, 4), -1, 1'b0, 1'b0, 1'b0);
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        k = 1'($urandom_range(0, 1));
                        b = 8'($urandom_range(0, 255));
                        if (k == ftrx_pkg::KIND_BYTE && b == p_start) b = ~b;
                        offer(k, b);
                    end
                end
            end
            drain();
        end

        repeat (80) @(posedge aclk);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/ftrx_pkg.sv
src/ftrx_msg_ram.sv
src/framed_text_receiver_xor_check_top.sv
tb/testbench.sv
